/* rtl/lvpt_pkg.sv */
`timescale 1ns / 1ps

package lvpt_pkg;

  // Fixed field widths of the item and result channels.
  localparam int THREAD_W = 2;
  localparam int VALUE_W  = 64;
  localparam int CONF_W   = 8;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONF_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_MODE = 1'd1;

  // Item modes.
  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  // A stored value equal to this marker never counts as a match.
  localparam logic [VALUE_W-1:0] INVALID_MARKER = 64'h0000_0000_dead_beef;

  // One table entry as held in the memory.
  typedef struct packed {
    logic                valid;
    logic [CONF_W-1:0]   conf;
    logic [VALUE_W-1:0]  value;
  } lvpt_entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE
  } lvpt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic resolve;
  } lvpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic item_predict;
    logic out_blocked;
  } lvpt_sts_t;

endpackage

/* rtl/lvpt_ctrl.sv */
`timescale 1ns / 1ps

module lvpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lvpt_pkg::lvpt_sts_t  sts,
  output lvpt_pkg::lvpt_cmd_t  cmd
);

  lvpt_pkg::lvpt_state_t state_r;
  lvpt_pkg::lvpt_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lvpt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      lvpt_pkg::ST_CLEAR: begin
        // Sweep the table once, zeroing every entry.
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = lvpt_pkg::ST_IDLE;
        end
      end
      lvpt_pkg::ST_IDLE: begin
        // Take one item and start the table read.
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = lvpt_pkg::ST_RESOLVE;
        end
      end
      lvpt_pkg::ST_RESOLVE: begin
        // A prediction waits here while out_stall holds a result in the output register.
        if (!(sts.item_predict && sts.out_blocked)) begin
          cmd.resolve = 1'b1;
          state_nxt   = lvpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lvpt_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/lvpt_dp.sv */
`timescale 1ns / 1ps

module lvpt_dp #(
  parameter int THREADS       = 4,
  parameter int PC_INDEX_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lvpt_pkg::lvpt_cmd_t               cmd,
  output lvpt_pkg::lvpt_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [lvpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lvpt_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_mode,
  input  logic [lvpt_pkg::THREAD_W-1:0]     in_thread,
  input  logic [PC_INDEX_BITS-1:0]          in_pc_index,
  input  logic [lvpt_pkg::VALUE_W-1:0]      in_actual_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_predict_valid,
  output logic [lvpt_pkg::VALUE_W-1:0]      out_predicted_value
);

  localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int AW    = TID_W + PC_INDEX_BITS;
  localparam int DEPTH = THREADS * (1 << PC_INDEX_BITS);

  lvpt_pkg::lvpt_entry_t mem [DEPTH];

  logic [lvpt_pkg::CFG_W-1:0]    conf_bits_r;
  logic                          clear_mode_r;
  logic [AW-1:0]                 clr_addr_r;
  logic                          mode_r;
  logic                          tid_ok_r;
  logic [AW-1:0]                 item_addr_r;
  logic [lvpt_pkg::VALUE_W-1:0]  actual_r;
  lvpt_pkg::lvpt_entry_t         rd_r;
  logic                          out_valid_r;
  logic                          out_pv_r;
  logic [lvpt_pkg::VALUE_W-1:0]  out_value_r;

  logic                          in_tid_ok;
  logic [AW-1:0]                 in_addr;
  logic [lvpt_pkg::CFG_W-1:0]    bits_clamped;
  logic [lvpt_pkg::CONF_W-1:0]   max_conf;
  logic                          pred_hit;
  logic                          is_match;
  lvpt_pkg::lvpt_entry_t         upd_entry;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  lvpt_pkg::lvpt_entry_t         wr_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_bits_r  <= lvpt_pkg::CFG_W'(2);
      clear_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == lvpt_pkg::REG_CONF_BITS) begin
        conf_bits_r <= cfg_wdata;
      end
      if (cfg_index == lvpt_pkg::REG_CLEAR_MODE) begin
        clear_mode_r <= cfg_wdata[0];
      end
    end
  end

  // Counter width clamped to one through eight; saturation is all ones.
  always_comb begin
    bits_clamped = conf_bits_r;
    if (conf_bits_r == '0) begin
      bits_clamped = lvpt_pkg::CFG_W'(1);
    end else if (conf_bits_r > lvpt_pkg::CFG_W'(8)) begin
      bits_clamped = lvpt_pkg::CFG_W'(8);
    end
    max_conf = lvpt_pkg::CONF_W'((9'd1 << bits_clamped) - 9'd1);
  end

  // Table address of an incoming item; unknown threads map to entry zero.
  assign in_tid_ok = (int'(in_thread) < THREADS);
  assign in_addr   = in_tid_ok ? {TID_W'(in_thread), in_pc_index} : '0;

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));

  // Item capture on transfer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r      <= in_mode;
      tid_ok_r    <= in_tid_ok;
      item_addr_r <= in_addr;
      actual_r    <= in_actual_value;
    end
  end

  // Table read, registered.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= mem[in_addr];
    end
  end

  // Prediction and training decision on the entry just read.
  always_comb begin
    pred_hit = tid_ok_r && rd_r.valid && (rd_r.conf >= max_conf);
    is_match = (actual_r != lvpt_pkg::INVALID_MARKER) && (actual_r == rd_r.value);
    upd_entry.valid = 1'b1;
    if (!rd_r.valid) begin
      upd_entry.conf  = '0;
      upd_entry.value = actual_r;
    end else if (is_match) begin
      upd_entry.value = rd_r.value;
      upd_entry.conf  = (rd_r.conf < max_conf) ? rd_r.conf + lvpt_pkg::CONF_W'(1) : max_conf;
    end else begin
      upd_entry.value = actual_r;
      if (clear_mode_r || rd_r.conf == '0) begin
        upd_entry.conf = '0;
      end else begin
        upd_entry.conf = rd_r.conf - lvpt_pkg::CONF_W'(1);
      end
    end
  end

  // Table write: clearing sweep or a training update.
  assign wr_en   = cmd.clr_wr || (cmd.resolve && mode_r == lvpt_pkg::MODE_UPDATE && tid_ok_r);
  assign wr_addr = cmd.clr_wr ? clr_addr_r : item_addr_r;
  assign wr_data = cmd.clr_wr ? '0 : upd_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Output register; a prediction loads it, a transfer empties it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resolve && mode_r == lvpt_pkg::MODE_PREDICT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && mode_r == lvpt_pkg::MODE_PREDICT) begin
      out_pv_r    <= pred_hit;
      out_value_r <= pred_hit ? rd_r.value : '0;
    end
  end

  assign sts.item_predict = (mode_r == lvpt_pkg::MODE_PREDICT);
  assign sts.out_blocked  = out_valid_r && out_stall;

  assign out_valid           = out_valid_r;
  assign out_predict_valid   = out_pv_r;
  assign out_predicted_value = out_value_r;

endmodule

/* rtl/last_value_predictor_table.sv */
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// cfg       cfg_we                cfg_index, cfg_wdata
// in        in_valid / in_stall   in_mode, in_thread, in_pc_index, in_actual_value
// out       out_valid / out_stall out_predict_valid, out_predicted_value
//
// An item is read from the table in ST_IDLE and resolved in ST_RESOLVE, set by
// the one read-modify-write of the single table memory; no new item is taken before
// it is resolved. After reset all THREADS << PC_INDEX_BITS entries (4096 at the
// defaults) are swept while in_stall stays high; configuration writes are taken.
// A prediction waits in its resolve cycle only while the output register holds
// an earlier result that out_stall keeps from moving; updates never wait.

module last_value_predictor_table #(
  parameter int THREADS       = 4,
  parameter int PC_INDEX_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lvpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lvpt_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [lvpt_pkg::THREAD_W-1:0]     in_thread,
  input  logic [PC_INDEX_BITS-1:0]          in_pc_index,
  input  logic [lvpt_pkg::VALUE_W-1:0]      in_actual_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_predict_valid,
  output logic [lvpt_pkg::VALUE_W-1:0]      out_predicted_value
);

  lvpt_pkg::lvpt_cmd_t cmd;
  lvpt_pkg::lvpt_sts_t sts;

  // Sequencing of the clearing sweep and of each item.
  lvpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, configuration and output register.
  lvpt_dp #(
    .THREADS       (THREADS),
    .PC_INDEX_BITS (PC_INDEX_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_mode),
    .in_thread           (in_thread),
    .in_pc_index         (in_pc_index),
    .in_actual_value     (in_actual_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predict_valid   (out_predict_valid),
    .out_predicted_value (out_predicted_value)
  );

endmodule
